// ===== rtl/core/wcs_pkg.sv =====
`default_nettype none
package wcs_pkg;

  // field widths
  localparam int DUR_W      = 21;
  localparam int PASS_W     = 2;
  localparam int DIST_W     = 6;
  localparam int MS_W       = 16;
  localparam int SENSE_W    = 8;
  localparam int KIND_W     = 2;
  localparam int PHASE_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;
  localparam int OUT_W      = 32;

  localparam int MAX_RINSES    = 3;
  localparam int TIME_BITS_DEF = 21;

  // register reset values
  localparam logic [DUR_W-1:0]  WASH_DUR_RST    = DUR_W'(600000);
  localparam logic [PASS_W-1:0] RINSE_PASS_RST  = PASS_W'(2);
  localparam logic [DIST_W-1:0] FILL_DIST_RST   = DIST_W'(12);
  localparam logic [DIST_W-1:0] EMPTY_DIST_RST  = DIST_W'(26);
  localparam logic [MS_W-1:0]   WASH_SPIN_RST   = MS_W'(5000);
  localparam logic [MS_W-1:0]   RINSE_SPIN_RST  = MS_W'(3000);
  localparam logic [MS_W-1:0]   REST_RST        = MS_W'(2000);
  localparam logic [DUR_W-1:0]  RINSE_DUR_RST   = DUR_W'(30000);

  // request kinds
  localparam logic [KIND_W-1:0] KIND_TICK        = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START_FULL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_START_RINSE = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WASH_DUR     = 3'd0,
    REG_RINSE_PASSES = 3'd1,
    REG_FILL_DIST    = 3'd2,
    REG_EMPTY_DIST   = 3'd3,
    REG_WASH_SPIN    = 3'd4,
    REG_RINSE_SPIN   = 3'd5,
    REG_REST         = 3'd6,
    REG_RINSE_DUR    = 3'd7
  } cfg_reg_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE        = 4'd0,
    PH_FILL        = 4'd1,
    PH_WASH_SPIN   = 4'd2,
    PH_WASH_REST   = 4'd3,
    PH_DRAIN       = 4'd4,
    PH_RINSE_FILL  = 4'd5,
    PH_RINSE_SPIN  = 4'd6,
    PH_RINSE_REST  = 4'd7,
    PH_RINSE_DRAIN = 4'd8,
    PH_FINAL_DRAIN = 4'd9
  } phase_t;

  typedef struct packed {
    logic [DUR_W-1:0]  wash_duration_ms;
    logic [PASS_W-1:0] rinse_passes;
    logic [DIST_W-1:0] fill_distance;
    logic [DIST_W-1:0] empty_distance;
    logic [MS_W-1:0]   wash_spin_ms;
    logic [MS_W-1:0]   rinse_spin_ms;
    logic [MS_W-1:0]   rest_ms;
    logic [DUR_W-1:0]  rinse_duration_ms;
  } cfg_t;

  typedef struct packed {
    phase_t            phase;
    logic [MS_W-1:0]   period_timer;
    logic [PASS_W-1:0] rinses_done;
    logic              direction;
    logic              full_cycle;
  } seq_state_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               motor_on;
    logic               motor_reverse;
    logic               inlet_open;
    logic               outlet_open;
    logic [PASS_W-1:0]  rinses_left;
    logic [DUR_W-1:0]   wash_left_ms;
    logic               job_done;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/wcs_cfg_regs.sv =====
`default_nettype none
module wcs_cfg_regs
  import wcs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wash_duration_ms  <= WASH_DUR_RST;
      cfg.rinse_passes      <= RINSE_PASS_RST;
      cfg.fill_distance     <= FILL_DIST_RST;
      cfg.empty_distance    <= EMPTY_DIST_RST;
      cfg.wash_spin_ms      <= WASH_SPIN_RST;
      cfg.rinse_spin_ms     <= RINSE_SPIN_RST;
      cfg.rest_ms           <= REST_RST;
      cfg.rinse_duration_ms <= RINSE_DUR_RST;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_WASH_DUR:     cfg.wash_duration_ms  <= wr_data[DUR_W-1:0];
        REG_RINSE_PASSES: cfg.rinse_passes      <= wr_data[PASS_W-1:0];
        REG_FILL_DIST:    cfg.fill_distance     <= wr_data[DIST_W-1:0];
        REG_EMPTY_DIST:   cfg.empty_distance    <= wr_data[DIST_W-1:0];
        REG_WASH_SPIN:    cfg.wash_spin_ms      <= wr_data[MS_W-1:0];
        REG_RINSE_SPIN:   cfg.rinse_spin_ms     <= wr_data[MS_W-1:0];
        REG_REST:         cfg.rest_ms           <= wr_data[MS_W-1:0];
        REG_RINSE_DUR:    cfg.rinse_duration_ms <= wr_data[DUR_W-1:0];
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/wcs_step.sv =====
`default_nettype none
module wcs_step
  import wcs_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire cfg_t                  cfg,
  input  wire seq_state_t            cur,
  input  wire logic [TIME_BITS-1:0]  elapsed,
  input  wire logic [KIND_W-1:0]     kind,
  input  wire logic [SENSE_W-1:0]    water_dist,
  output seq_state_t                 nxt,
  output logic      [TIME_BITS-1:0]  elapsed_next,
  output result_t                    res
);

  localparam int CMP_W = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;

  logic              idle;
  logic [PASS_W-1:0] pass_cnt;
  logic              below_fill;
  logic              reached_empty;
  logic              is_wash;
  logic [MS_W-1:0]   spin_len;
  logic [DUR_W-1:0]  agit_dur;
  phase_t            spin_ph;
  phase_t            rest_ph;
  phase_t            after_ph;
  logic [TIME_BITS-1:0] elapsed_inc;
  logic [MS_W-1:0]   pt_inc;
  logic              keep_going;
  logic [PASS_W-1:0] rd_inc;
  logic              done;
  phase_t            ph;
  logic [CMP_W-1:0]  el_ext;
  logic [CMP_W-1:0]  wd_ext;
  logic [CMP_W-1:0]  wl_diff;

  always_comb begin
    idle = (cur.phase == PH_IDLE);
    pass_cnt = (32'(cfg.rinse_passes) > MAX_RINSES) ? PASS_W'(MAX_RINSES) : cfg.rinse_passes;
    below_fill = water_dist < SENSE_W'(cfg.fill_distance);
    reached_empty = water_dist >= SENSE_W'(cfg.empty_distance);

    // shared agitation step for wash and rinse
    is_wash  = (cur.phase == PH_WASH_SPIN) || (cur.phase == PH_WASH_REST);
    spin_len = is_wash ? cfg.wash_spin_ms : cfg.rinse_spin_ms;
    agit_dur = is_wash ? cfg.wash_duration_ms : cfg.rinse_duration_ms;
    spin_ph  = is_wash ? PH_WASH_SPIN : PH_RINSE_SPIN;
    rest_ph  = is_wash ? PH_WASH_REST : PH_RINSE_REST;
    after_ph = is_wash ? PH_DRAIN : PH_RINSE_DRAIN;
    elapsed_inc = (elapsed != '1) ? elapsed + TIME_BITS'(1) : elapsed;
    pt_inc = cur.period_timer + MS_W'(1);
    keep_going = CMP_W'(elapsed_inc) <= CMP_W'(agit_dur);
    rd_inc = cur.rinses_done + PASS_W'(1);

    nxt = cur;
    elapsed_next = elapsed;
    done = 1'b0;

    if (kind == KIND_START_FULL && idle) begin
      nxt.full_cycle = 1'b1;
      nxt.rinses_done = '0;
      nxt.period_timer = '0;
      elapsed_next = '0;
      nxt.phase = (cfg.wash_duration_ms != '0) ? PH_FILL : PH_DRAIN;
    end else if (kind == KIND_START_RINSE && idle) begin
      nxt.full_cycle = 1'b0;
      nxt.rinses_done = '0;
      nxt.period_timer = '0;
      elapsed_next = '0;
      if (pass_cnt == '0) begin
        nxt.phase = PH_IDLE;
        done = 1'b1;
      end else begin
        nxt.phase = PH_RINSE_FILL;
      end
    end else if (kind == KIND_TICK) begin
      unique case (cur.phase)
        PH_IDLE: ;
        PH_FILL, PH_RINSE_FILL: begin
          if (below_fill) begin
            elapsed_next = '0;
            nxt.direction = ~cur.direction;
            nxt.period_timer = '0;
            nxt.phase = (cur.phase == PH_FILL) ? PH_WASH_SPIN : PH_RINSE_SPIN;
          end
        end
        PH_WASH_SPIN, PH_WASH_REST, PH_RINSE_SPIN, PH_RINSE_REST: begin
          elapsed_next = elapsed_inc;
          nxt.period_timer = pt_inc;
          // period end: spin done with no rest, or rest done
          if ((cur.phase == spin_ph && pt_inc >= spin_len && cfg.rest_ms == '0) ||
              (cur.phase == rest_ph && pt_inc >= cfg.rest_ms)) begin
            nxt.period_timer = '0;
            if (keep_going) begin
              nxt.direction = ~cur.direction;
              nxt.phase = spin_ph;
            end else begin
              nxt.phase = after_ph;
            end
          end else if (cur.phase == spin_ph && pt_inc >= spin_len) begin
            nxt.period_timer = '0;
            nxt.phase = rest_ph;
          end
        end
        PH_DRAIN: begin
          if (reached_empty) begin
            nxt.phase = (cur.rinses_done < pass_cnt) ? PH_RINSE_FILL : PH_FINAL_DRAIN;
          end
        end
        PH_RINSE_DRAIN: begin
          if (reached_empty) begin
            nxt.rinses_done = rd_inc;
            if (rd_inc < pass_cnt) begin
              nxt.phase = PH_RINSE_FILL;
            end else if (cur.full_cycle) begin
              nxt.phase = PH_FINAL_DRAIN;
            end else begin
              nxt.phase = PH_IDLE;
              done = 1'b1;
            end
          end
        end
        PH_FINAL_DRAIN: begin
          if (reached_empty) begin
            nxt.phase = PH_IDLE;
            done = 1'b1;
          end
        end
        default: nxt.phase = PH_IDLE;
      endcase
    end

    // result from the updated state
    ph = nxt.phase;
    el_ext = CMP_W'(elapsed_next);
    wd_ext = CMP_W'(cfg.wash_duration_ms);
    wl_diff = wd_ext - el_ext;
    res.phase = ph;
    res.motor_on = (ph == PH_WASH_SPIN) || (ph == PH_RINSE_SPIN);
    res.motor_reverse = nxt.direction;
    res.inlet_open = (ph == PH_FILL) || (ph == PH_RINSE_FILL);
    res.outlet_open = (ph == PH_DRAIN) || (ph == PH_RINSE_DRAIN) || (ph == PH_FINAL_DRAIN);
    res.rinses_left = (ph != PH_IDLE && nxt.rinses_done < pass_cnt) ?
                      pass_cnt - nxt.rinses_done : '0;
    if (ph == PH_FILL) begin
      res.wash_left_ms = cfg.wash_duration_ms;
    end else if ((ph == PH_WASH_SPIN || ph == PH_WASH_REST) && el_ext < wd_ext) begin
      res.wash_left_ms = wl_diff[DUR_W-1:0];
    end else begin
      res.wash_left_ms = '0;
    end
    res.job_done = done;
  end

endmodule
`default_nettype wire

// ===== rtl/core/wash_cycle_sequencer.sv =====
// path: an accepted request goes to the input register, and its result is on m_tdata
// once it moves on to the result register, later only while m_tready holds it back
// throughput: one request per cycle while m_tready does not hold the result back; one
// update step sits between the input register and the result register
// reset (rst, synchronous): idle phase, timers and counters cleared, registers
// at their default values, both stream sides empty
`default_nettype none
module wash_cycle_sequencer
  import wcs_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [SENSE_W-1:0]    s_tdata,   // [7:0] water_distance
  input  wire logic [KIND_W-1:0]     s_tuser,   // [1:0] kind
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // [3:0] phase, [4] motor_on, [5] motor_reverse, [6] inlet_open,
  // [7] outlet_open, [9:8] rinses_left, [30:10] wash_left_ms, [31] job_done
  output logic [OUT_W-1:0]           m_tdata,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t                 cfg;
  seq_state_t           state;
  seq_state_t           state_next;
  logic [TIME_BITS-1:0] elapsed;
  logic [TIME_BITS-1:0] elapsed_next;
  result_t              res;
  logic                 in_valid;
  logic [KIND_W-1:0]    in_kind;
  logic [SENSE_W-1:0]   in_dist;
  logic                 advance;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;

  wcs_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  wcs_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .cfg          (cfg),
    .cur          (state),
    .elapsed      (elapsed),
    .kind         (in_kind),
    .water_dist   (in_dist),
    .nxt          (state_next),
    .elapsed_next (elapsed_next),
    .res          (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_kind <= s_tuser;
      in_dist <= s_tdata;
    end
  end

  // sequencer state commits when the request moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase        <= PH_IDLE;
      state.period_timer <= '0;
      state.rinses_done  <= '0;
      state.direction    <= 1'b0;
      state.full_cycle   <= 1'b0;
      elapsed            <= '0;
    end else if (advance) begin
      state   <= state_next;
      elapsed <= elapsed_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {res.job_done, res.wash_left_ms, res.rinses_left, res.outlet_open,
                  res.inlet_open, res.motor_reverse, res.motor_on, res.phase};
    end
  end

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import wcs_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned RANDOM_REQUESTS = 550;

  typedef struct {
    logic [PHASE_W-1:0] phase;
    logic               motor_on;
    logic               motor_reverse;
    logic               inlet_open;
    logic               outlet_open;
    logic [PASS_W-1:0]  rinses_left;
    logic [DUR_W-1:0]   wash_left_ms;
    logic               job_done;
  } outcome_t;

  // shadow copy of the sequencer: steps on every accepted request and
  // queues the outcome the block should report for it
  class washer_shadow;
    logic [DUR_W-1:0]  wash_dur;
    logic [PASS_W-1:0] passes;
    logic [DIST_W-1:0] fill_dist;
    logic [DIST_W-1:0] empty_dist;
    logic [MS_W-1:0]   wash_spin;
    logic [MS_W-1:0]   rinse_spin;
    logic [MS_W-1:0]   rest_ms;
    logic [DUR_W-1:0]  rinse_dur;

    phase_t                   ph;
    logic [MS_W-1:0]          period;
    logic [TIME_BITS_DEF-1:0] elapsed;
    logic [PASS_W-1:0]        rinses;
    logic                     dir;
    logic                     full;

    outcome_t pending[$];
    int       errors;

    function new();
      wash_dur   = WASH_DUR_RST;
      passes     = RINSE_PASS_RST;
      fill_dist  = FILL_DIST_RST;
      empty_dist = EMPTY_DIST_RST;
      wash_spin  = WASH_SPIN_RST;
      rinse_spin = RINSE_SPIN_RST;
      rest_ms    = REST_RST;
      rinse_dur  = RINSE_DUR_RST;
      ph         = PH_IDLE;
      period     = '0;
      elapsed    = '0;
      rinses     = '0;
      dir        = 1'b0;
      full       = 1'b0;
      errors     = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_WASH_DUR:     wash_dur   = v[DUR_W-1:0];
        REG_RINSE_PASSES: passes     = v[PASS_W-1:0];
        REG_FILL_DIST:    fill_dist  = v[DIST_W-1:0];
        REG_EMPTY_DIST:   empty_dist = v[DIST_W-1:0];
        REG_WASH_SPIN:    wash_spin  = v[MS_W-1:0];
        REG_RINSE_SPIN:   rinse_spin = v[MS_W-1:0];
        REG_REST:         rest_ms    = v[MS_W-1:0];
        REG_RINSE_DUR:    rinse_dur  = v[DUR_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [PASS_W-1:0] pass_count();
      return (passes > MAX_RINSES) ? PASS_W'(MAX_RINSES) : passes;
    endfunction

    function void start_rotation(phase_t spin_ph);
      dir    = ~dir;
      period = '0;
      ph     = spin_ph;
    endfunction

    function void close_period(logic [DUR_W-1:0] dur, phase_t spin_ph, phase_t next_ph);
      period = '0;
      if (elapsed <= dur) start_rotation(spin_ph);
      else ph = next_ph;
    endfunction

    function void agitate(logic [MS_W-1:0] spin, logic [DUR_W-1:0] dur,
                          phase_t spin_ph, phase_t rest_ph, phase_t next_ph);
      if (elapsed != '1) elapsed = elapsed + 1'b1;
      period = period + 1'b1;
      if (ph == spin_ph) begin
        if (period >= spin) begin
          period = '0;
          // no rest time: the period closes on the tick the spin ends
          if (rest_ms == 0) close_period(dur, spin_ph, next_ph);
          else ph = rest_ph;
        end
      end else if (period >= rest_ms) begin
        close_period(dur, spin_ph, next_ph);
      end
    endfunction

    function void accept_request(logic [KIND_W-1:0] kind, logic [SENSE_W-1:0] water);
      outcome_t o;
      logic     done;
      logic     idle;
      done = 1'b0;
      idle = (ph == PH_IDLE);
      if (kind == KIND_START_FULL && idle) begin
        full    = 1'b1;
        rinses  = '0;
        period  = '0;
        elapsed = '0;
        ph      = (wash_dur != 0) ? PH_FILL : PH_DRAIN;
      end else if (kind == KIND_START_RINSE && idle) begin
        full    = 1'b0;
        rinses  = '0;
        period  = '0;
        elapsed = '0;
        if (pass_count() == 0) begin
          ph   = PH_IDLE;
          done = 1'b1;
        end else begin
          ph = PH_RINSE_FILL;
        end
      end else if (kind == KIND_TICK) begin
        case (ph)
          PH_FILL: begin
            if (water < fill_dist) begin
              elapsed = '0;
              start_rotation(PH_WASH_SPIN);
            end
          end
          PH_WASH_SPIN, PH_WASH_REST: begin
            agitate(wash_spin, wash_dur, PH_WASH_SPIN, PH_WASH_REST, PH_DRAIN);
          end
          PH_DRAIN: begin
            if (water >= empty_dist)
              ph = (rinses < pass_count()) ? PH_RINSE_FILL : PH_FINAL_DRAIN;
          end
          PH_RINSE_FILL: begin
            if (water < fill_dist) begin
              elapsed = '0;
              start_rotation(PH_RINSE_SPIN);
            end
          end
          PH_RINSE_SPIN, PH_RINSE_REST: begin
            agitate(rinse_spin, rinse_dur, PH_RINSE_SPIN, PH_RINSE_REST, PH_RINSE_DRAIN);
          end
          PH_RINSE_DRAIN: begin
            if (water >= empty_dist) begin
              rinses = rinses + 1'b1;
              if (rinses < pass_count()) ph = PH_RINSE_FILL;
              else if (full) ph = PH_FINAL_DRAIN;
              else begin
                ph   = PH_IDLE;
                done = 1'b1;
              end
            end
          end
          PH_FINAL_DRAIN: begin
            if (water >= empty_dist) begin
              ph   = PH_IDLE;
              done = 1'b1;
            end
          end
          default: ph = PH_IDLE;
        endcase
      end
      // busy starts and the unused kind leave the state alone

      o.phase         = ph;
      o.motor_on      = (ph == PH_WASH_SPIN || ph == PH_RINSE_SPIN);
      o.motor_reverse = dir;
      o.inlet_open    = (ph == PH_FILL || ph == PH_RINSE_FILL);
      o.outlet_open   = (ph == PH_DRAIN || ph == PH_RINSE_DRAIN || ph == PH_FINAL_DRAIN);
      o.rinses_left   = (ph != PH_IDLE && rinses < pass_count()) ? pass_count() - rinses : '0;
      if (ph == PH_FILL) o.wash_left_ms = wash_dur;
      else if (ph == PH_WASH_SPIN || ph == PH_WASH_REST)
        o.wash_left_ms = (elapsed < wash_dur) ? wash_dur - elapsed : '0;
      else o.wash_left_ms = '0;
      o.job_done = done;
      pending.push_back(o);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_outcome(logic [OUT_W-1:0] d);
      outcome_t w;
      if (pending.size() == 0) begin
        $error("result %h with no request outstanding", d);
        errors++;
        return;
      end
      w = pending.pop_front();
      compare_field("phase", w.phase, d[3:0]);
      compare_field("motor_on", w.motor_on, d[4]);
      compare_field("motor_reverse", w.motor_reverse, d[5]);
      compare_field("inlet_open", w.inlet_open, d[6]);
      compare_field("outlet_open", w.outlet_open, d[7]);
      compare_field("rinses_left", w.rinses_left, d[9:8]);
      compare_field("wash_left_ms", w.wash_left_ms, d[30:10]);
      compare_field("job_done", w.job_done, d[31]);
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [SENSE_W-1:0]    s_tdata;
  logic [KIND_W-1:0]     s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_W-1:0]      m_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bit calm;
  bit hold_request;

  washer_shadow shadow = new();

  wash_cycle_sequencer uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #200000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) shadow.accept_request(s_tuser, s_tdata);
    if (!rst && m_tvalid && m_tready) shadow.check_outcome(m_tdata);
  end

  // result side: random stalls, a calm stretch, and one long hold-off
  initial begin : sink
    int unsigned hold_left;
    hold_left = 0;
    m_tready  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 60;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(0, 99) >= 25);
      end
    end
  end

  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [SENSE_W-1:0] water);
    while (!calm && $urandom_range(0, 99) < 25) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= water;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // caller lowers cfg_valid after the last write of a batch
  task automatic program_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow.set_reg(idx, v);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (shadow.pending.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] draw_setting(int unsigned typ_max,
                                                          int unsigned ext_max);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return CFG_DATA_W'(ext_max);
    return CFG_DATA_W'($urandom_range(0, typ_max));
  endfunction

  // levels are steered so fills and drains actually finish
  function automatic logic [SENSE_W-1:0] draw_level();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40 && shadow.fill_dist != 0)
      return SENSE_W'($urandom_range(0, shadow.fill_dist - 1));
    if (r < 80) return SENSE_W'($urandom_range(shadow.empty_dist, 255));
    return SENSE_W'($urandom_range(0, 255));
  endfunction

  task automatic pick_config(input bit all_regs);
    if (all_regs || $urandom_range(0, 99) < 60)
      program_reg(REG_WASH_DUR, draw_setting(40, 1200000));
    if (all_regs || $urandom_range(0, 99) < 60)
      program_reg(REG_RINSE_PASSES, CFG_DATA_W'($urandom_range(0, 3)));
    if (all_regs || $urandom_range(0, 99) < 60)
      program_reg(REG_FILL_DIST, CFG_DATA_W'($urandom_range(0, 63)));
    if (all_regs || $urandom_range(0, 99) < 60)
      program_reg(REG_EMPTY_DIST, CFG_DATA_W'($urandom_range(0, 63)));
    if (all_regs || $urandom_range(0, 99) < 60)
      program_reg(REG_WASH_SPIN, draw_setting(6, 65535));
    if (all_regs || $urandom_range(0, 99) < 60)
      program_reg(REG_RINSE_SPIN, draw_setting(6, 65535));
    if (all_regs || $urandom_range(0, 99) < 60)
      program_reg(REG_REST, draw_setting(4, 65535));
    if (all_regs || $urandom_range(0, 99) < 60)
      program_reg(REG_RINSE_DUR, draw_setting(15, 1200000));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned      sent;
    int unsigned      n;
    int unsigned      r;
    logic [KIND_W-1:0] kind;
    bit               first;

    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = KIND_TICK;
    cfg_valid = 1'b0;
    cfg_index = REG_WASH_DUR;
    cfg_data  = '0;
    calm      = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // idle with the default settings
    send_request(KIND_UNUSED, 8'd255);
    send_request(KIND_TICK, 8'd0);

    // short full cycle: zero wash spin, zero rest, one rinse
    settle();
    program_reg(REG_WASH_DUR, 21'd3);
    program_reg(REG_RINSE_PASSES, 21'd1);
    program_reg(REG_FILL_DIST, 21'd10);
    program_reg(REG_EMPTY_DIST, 21'd40);
    program_reg(REG_WASH_SPIN, 21'd0);
    program_reg(REG_RINSE_SPIN, 21'd1);
    program_reg(REG_REST, 21'd0);
    program_reg(REG_RINSE_DUR, 21'd1);
    cfg_valid <= 1'b0;
    send_request(KIND_START_FULL, 8'd255);
    send_request(KIND_START_FULL, 8'd0);
    send_request(KIND_TICK, 8'd20);
    send_request(KIND_TICK, 8'd9);
    repeat (4) send_request(KIND_TICK, 8'd0);
    send_request(KIND_TICK, 8'd39);
    send_request(KIND_TICK, 8'd40);
    send_request(KIND_START_RINSE, 8'd0);
    send_request(KIND_TICK, 8'd9);
    repeat (2) send_request(KIND_TICK, 8'd0);
    send_request(KIND_TICK, 8'd255);
    send_request(KIND_TICK, 8'd63);

    // rinse-only with no passes finishes on the start itself
    settle();
    program_reg(REG_RINSE_PASSES, 21'd0);
    cfg_valid <= 1'b0;
    send_request(KIND_START_RINSE, 8'd128);

    // every register at the largest value the bench draws; the fill never ends here and the
    // random settings below take over mid-cycle
    settle();
    program_reg(REG_WASH_DUR, 21'd1200000);
    program_reg(REG_RINSE_PASSES, 21'd3);
    program_reg(REG_FILL_DIST, 21'd63);
    program_reg(REG_EMPTY_DIST, 21'd63);
    program_reg(REG_WASH_SPIN, 21'd65535);
    program_reg(REG_RINSE_SPIN, 21'd65535);
    program_reg(REG_REST, 21'd65535);
    program_reg(REG_RINSE_DUR, 21'd1200000);
    cfg_valid <= 1'b0;
    send_request(KIND_START_FULL, 8'd200);
    send_request(KIND_TICK, 8'd255);
    send_request(KIND_TICK, 8'd63);

    first = 1'b1;
    sent  = 0;
    while (sent < RANDOM_REQUESTS) begin
      settle();
      pick_config(first);
      first = 1'b0;
      n = $urandom_range(20, 60);
      repeat (n) begin
        calm = (sent >= 250 && sent < 350);
        if (sent == 100) hold_request = 1'b1;
        r = $urandom_range(0, 99);
        if (r < 7) kind = KIND_START_FULL;
        else if (r < 12) kind = KIND_START_RINSE;
        else if (r < 14) kind = KIND_UNUSED;
        else kind = KIND_TICK;
        send_request(kind, draw_level());
        if (kind != KIND_UNUSED) sent++;
      end
    end
    calm = 1'b0;

    settle();
    repeat (10) @(posedge clk);
    if (shadow.errors == 0 && shadow.pending.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
